// File: rtl/core/serial_record_loader_top_assert.svh
// assertion macros used by the loader checker
`ifndef SERIAL_RECORD_LOADER_TOP_ASSERT_SVH
`define SERIAL_RECORD_LOADER_TOP_ASSERT_SVH

// same-cycle implication, checked on every edge outside reset
`define SRL_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every edge outside reset
`define SRL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/srl_pkg.sv
// shared constants, codes, command/status types and lookup tables of the record loader
package srl_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_WIDTH   = 24;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int CMP_W        = ((IDX_W > 8) ? IDX_W : 8) + 1;
  localparam int FIT_W        = CMP_W + 1;

  typedef logic [7:0] byte_t;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WR   = 2'd1;
  localparam logic [1:0] KIND_PROG = 2'd2;

  // header characters
  localparam byte_t CH_HAND  = "!";
  localparam byte_t CH_UPD   = "u";
  localparam byte_t CH_REC   = ":";
  localparam byte_t CH_QUERY = "?";
  localparam byte_t CH_PROG  = "w";

  // byte operations on the parse registers
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_START = 3'd1;
  localparam op_t OP_HAND  = 3'd2;
  localparam op_t OP_UPD   = 3'd3;
  localparam op_t OP_LEN   = 3'd4;
  localparam op_t OP_HDR   = 3'd5;
  localparam op_t OP_DATA  = 3'd6;

  // reply strings
  typedef logic [1:0] msg_t;
  localparam msg_t MSG_LORDY = 2'd0;
  localparam msg_t MSG_SURE  = 2'd1;
  localparam msg_t MSG_OK    = 2'd2;
  localparam msg_t MSG_ER    = 2'd3;

  // decoded header byte
  typedef logic [2:0] hdr_t;
  localparam hdr_t HDR_NONE  = 3'd0;
  localparam hdr_t HDR_HAND  = 3'd1;
  localparam hdr_t HDR_UPD   = 3'd2;
  localparam hdr_t HDR_REC   = 3'd3;
  localparam hdr_t HDR_QUERY = 3'd4;
  localparam hdr_t HDR_PROG  = 3'd5;

  typedef struct packed {
    logic take;
    op_t  op;
    logic ld_msg;
    msg_t msg;
    logic set_verdict;
    logic rd_issue;
    logic clr_idx;
    logic ld_wr;
    logic ld_char;
    logic ld_prog;
  } cmd_t;

  typedef struct packed {
    hdr_t hdr;
    logic hand_done;
    logic hand_match;
    logic upd_done;
    logic upd_match;
    logic hdr_done;
    logic len_zero;
    logic data_done;
    logic csum_ok;
    logic verdict_ok;
    logic wr_more;
    logic char_last;
    logic slot_free;
  } sts_t;

  // handshake call, sixteen characters
  function automatic byte_t hand_char(logic [3:0] idx);
    byte_t c;
    case (idx)
      4'd0:    c = "w";
      4'd1:    c = "h";
      4'd2:    c = "o";
      4'd3:    c = "_";
      4'd4:    c = "i";
      4'd5:    c = "s";
      4'd6:    c = "_";
      4'd7:    c = "t";
      4'd8:    c = "h";
      4'd9:    c = "e";
      4'd10:   c = "r";
      4'd11:   c = "e";
      4'd12:   c = "?";
      default: c = " ";
    endcase
    return c;
  endfunction

  // update call, five characters
  function automatic byte_t upd_char(logic [2:0] idx);
    byte_t c;
    case (idx)
      3'd0:    c = "p";
      3'd1:    c = "d";
      3'd2:    c = "a";
      3'd3:    c = "t";
      default: c = "e";
    endcase
    return c;
  endfunction

  function automatic byte_t msg_char(msg_t msg, logic [2:0] idx);
    byte_t c;
    c = " ";
    case (msg)
      MSG_LORDY: begin
        case (idx)
          3'd0:    c = "l";
          3'd1:    c = "o";
          3'd2:    c = "r";
          3'd3:    c = "d";
          default: c = "y";
        endcase
      end
      MSG_SURE: begin
        case (idx)
          3'd0:    c = "s";
          3'd1:    c = "u";
          3'd2:    c = "r";
          default: c = "e";
        endcase
      end
      MSG_OK:  c = (idx == 3'd0) ? byte_t'("o") : byte_t'("k");
      default: c = (idx == 3'd0) ? byte_t'("e") : byte_t'("r");
    endcase
    return c;
  endfunction

  // index of the final character of a reply
  function automatic logic [2:0] msg_last(msg_t msg);
    logic [2:0] n;
    case (msg)
      MSG_LORDY: n = 3'd4;
      MSG_SURE:  n = 3'd3;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/srl_ifs.sv
// valid/ready channel interfaces for received bytes and result beats
interface srl_in_if;
  import srl_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srl_out_if;
  import srl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  byte_t                 tx_byte;
  logic [ADDR_WIDTH-1:0] mem_addr;
  byte_t                 mem_data;
  logic                  last;

  modport source (output valid, output kind, output tx_byte, output mem_addr,
                  output mem_data, output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input mem_addr,
                  input mem_data, input last, output ready);
endinterface

// File: rtl/core/srl_ctrl.sv
// controller: message parser and reply sequencer state machine
module srl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_ready,
  input  srl_pkg::sts_t sts,
  output srl_pkg::cmd_t cmd
);
  import srl_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HAND = 4'd1;
  localparam logic [3:0] ST_UPD  = 4'd2;
  localparam logic [3:0] ST_LEN  = 4'd3;
  localparam logic [3:0] ST_HDR  = 4'd4;
  localparam logic [3:0] ST_DATA = 4'd5;
  localparam logic [3:0] ST_CSUM = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_WR   = 4'd8;
  localparam logic [3:0] ST_TXT  = 4'd9;
  localparam logic [3:0] ST_PROG = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    rx_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.take = 1'b1;
          case (sts.hdr)
            HDR_HAND: begin
              cmd.op     = OP_START;
              state_next = ST_HAND;
            end
            HDR_UPD: begin
              cmd.op     = OP_START;
              state_next = ST_UPD;
            end
            HDR_REC: state_next = ST_LEN;
            HDR_QUERY: begin
              cmd.ld_msg = 1'b1;
              cmd.msg    = sts.verdict_ok ? MSG_OK : MSG_ER;
              state_next = ST_TXT;
            end
            HDR_PROG: state_next = ST_PROG;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_HAND: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.take = 1'b1;
          cmd.op   = OP_HAND;
          if (sts.hand_done) begin
            cmd.ld_msg = 1'b1;
            cmd.msg    = MSG_LORDY;
            state_next = sts.hand_match ? ST_TXT : ST_IDLE;
          end
        end
      end
      ST_UPD: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.take = 1'b1;
          cmd.op   = OP_UPD;
          if (sts.upd_done) begin
            cmd.ld_msg = 1'b1;
            cmd.msg    = MSG_SURE;
            state_next = sts.upd_match ? ST_TXT : ST_IDLE;
          end
        end
      end
      ST_LEN: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.take   = 1'b1;
          cmd.op     = OP_LEN;
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.take = 1'b1;
          cmd.op   = OP_HDR;
          if (sts.hdr_done) begin
            state_next = sts.len_zero ? ST_CSUM : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.take = 1'b1;
          cmd.op   = OP_DATA;
          if (sts.data_done) begin
            state_next = ST_CSUM;
          end
        end
      end
      ST_CSUM: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.take        = 1'b1;
          cmd.set_verdict = 1'b1;
          cmd.ld_msg      = 1'b1;
          if (sts.csum_ok) begin
            cmd.msg = MSG_OK;
            if (sts.len_zero) begin
              state_next = ST_TXT;
            end else begin
              cmd.clr_idx = 1'b1;
              state_next  = ST_RD;
            end
          end else begin
            cmd.msg    = MSG_ER;
            state_next = ST_TXT;
          end
        end
      end
      // fetch one buffered data byte
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_WR;
      end
      // hand the fetched byte out as a memory write
      ST_WR: begin
        if (sts.slot_free) begin
          cmd.ld_wr  = 1'b1;
          state_next = sts.wr_more ? ST_RD : ST_TXT;
        end
      end
      ST_TXT: begin
        if (sts.slot_free) begin
          cmd.ld_char = 1'b1;
          if (sts.char_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PROG: begin
        if (sts.slot_free) begin
          cmd.ld_prog = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/srl_dp.sv
// datapath: parse registers, record buffer, write address and output register
module srl_dp (
  input  logic           clk,
  input  logic           rst,
  input  srl_pkg::byte_t rx_byte,
  input  srl_pkg::cmd_t  cmd,
  output srl_pkg::sts_t  sts,
  srl_out_if.source      res
);
  import srl_pkg::*;

  // parse state
  byte_t                 byte_count;
  byte_t                 record_length;
  byte_t                 running_sum;
  logic                  string_match;
  logic                  last_verdict_ok;
  logic [ADDR_WIDTH-1:0] write_address;

  // record buffer
  byte_t                 data_buffer [BUFFER_DEPTH];
  byte_t                 rd_data;
  logic [IDX_W-1:0]      emit_idx;

  // reply sequencing
  msg_t                  msg;
  logic [2:0]            char_idx;

  // output register
  logic                  out_valid;
  logic [1:0]            out_kind;
  byte_t                 out_tx_byte;
  logic [ADDR_WIDTH-1:0] out_mem_addr;
  byte_t                 out_mem_data;
  logic                  out_last;

  logic [CMP_W-1:0]      bc_ext;
  logic                  buf_wr;
  logic                  fits;
  byte_t                 sum_neg;
  byte_t                 sum_add;
  hdr_t                  hdr_dec;

  assign bc_ext  = CMP_W'(byte_count);
  assign buf_wr  = cmd.take && (cmd.op == OP_DATA) && (bc_ext < CMP_W'(BUFFER_DEPTH));
  assign fits    = (FIT_W'(record_length) + FIT_W'(5)) <= FIT_W'(BUFFER_DEPTH);
  assign sum_neg = ~running_sum + 8'd1;
  assign sum_add = running_sum + rx_byte;

  // header decode of the received byte
  always_comb begin
    unique case (rx_byte)
      CH_HAND:  hdr_dec = HDR_HAND;
      CH_UPD:   hdr_dec = HDR_UPD;
      CH_REC:   hdr_dec = HDR_REC;
      CH_QUERY: hdr_dec = HDR_QUERY;
      CH_PROG:  hdr_dec = HDR_PROG;
      default:  hdr_dec = HDR_NONE;
    endcase
  end

  // status toward the controller
  assign sts.hdr        = hdr_dec;
  assign sts.hand_done  = (byte_count == 8'd15);
  assign sts.hand_match = string_match && (rx_byte == hand_char(byte_count[3:0]));
  assign sts.upd_done   = (byte_count == 8'd4);
  assign sts.upd_match  = string_match && (rx_byte == upd_char(byte_count[2:0]));
  assign sts.hdr_done   = (byte_count == 8'd2);
  assign sts.len_zero   = (record_length == 8'd0);
  assign sts.data_done  = (9'(byte_count) + 9'd1) >= 9'(record_length);
  assign sts.csum_ok    = fits && (sum_neg == rx_byte);
  assign sts.verdict_ok = last_verdict_ok;
  assign sts.wr_more    = (CMP_W'(emit_idx) + CMP_W'(1)) < CMP_W'(record_length);
  assign sts.char_last  = (char_idx == msg_last(msg));
  assign sts.slot_free  = !out_valid || res.ready;

  // parse registers, updated per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      record_length   <= '0;
      running_sum     <= '0;
      string_match    <= 1'b1;
      last_verdict_ok <= 1'b0;
    end else begin
      if (cmd.take) begin
        case (cmd.op)
          OP_START: begin
            byte_count   <= '0;
            string_match <= 1'b1;
          end
          OP_HAND: begin
            string_match <= sts.hand_match;
            byte_count   <= byte_count + 8'd1;
          end
          OP_UPD: begin
            string_match <= sts.upd_match;
            byte_count   <= byte_count + 8'd1;
          end
          OP_LEN: begin
            record_length <= rx_byte;
            running_sum   <= rx_byte;
            byte_count    <= '0;
          end
          OP_HDR: begin
            running_sum <= sum_add;
            byte_count  <= sts.hdr_done ? 8'd0 : byte_count + 8'd1;
          end
          OP_DATA: begin
            running_sum <= sum_add;
            byte_count  <= byte_count + 8'd1;
          end
          default: ;
        endcase
      end
      if (cmd.set_verdict) begin
        last_verdict_ok <= sts.csum_ok;
      end
    end
  end

  // buffer write port and registered read port
  always_ff @(posedge clk) begin
    if (buf_wr) begin
      data_buffer[bc_ext[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= data_buffer[emit_idx];
    end
  end

  // write address, drain index and reply character index
  always_ff @(posedge clk) begin
    if (rst) begin
      write_address <= '0;
      emit_idx      <= '0;
      char_idx      <= '0;
      msg           <= MSG_ER;
    end else begin
      if (cmd.clr_idx) begin
        emit_idx <= '0;
      end else if (cmd.ld_wr) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end
      if (cmd.ld_wr) begin
        write_address <= write_address + ADDR_WIDTH'(1);
      end
      if (cmd.ld_msg) begin
        msg      <= cmd.msg;
        char_idx <= '0;
      end else if (cmd.ld_char) begin
        char_idx <= char_idx + 3'd1;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_wr || cmd.ld_char || cmd.ld_prog) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload, unused fields held at zero
  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      out_kind     <= KIND_WR;
      out_tx_byte  <= '0;
      out_mem_addr <= write_address;
      out_mem_data <= rd_data;
      out_last     <= 1'b0;
    end else if (cmd.ld_char) begin
      out_kind     <= KIND_TX;
      out_tx_byte  <= msg_char(msg, char_idx);
      out_mem_addr <= '0;
      out_mem_data <= '0;
      out_last     <= sts.char_last;
    end else if (cmd.ld_prog) begin
      out_kind     <= KIND_PROG;
      out_tx_byte  <= '0;
      out_mem_addr <= '0;
      out_mem_data <= '0;
      out_last     <= 1'b1;
    end
  end

  assign res.valid    = out_valid;
  assign res.kind     = out_kind;
  assign res.tx_byte  = out_tx_byte;
  assign res.mem_addr = out_mem_addr;
  assign res.mem_data = out_mem_data;
  assign res.last     = out_last;

endmodule

// File: rtl/core/serial_record_loader_top.sv
// top level of the serial record loader
//
//  channel  dir  beat contents                                  handshake
//  rx       in   rx_byte                                        valid/ready
//  res      out  kind, tx_byte, mem_addr, mem_data, last         valid/ready
//
// a received byte that causes no result is taken in the cycle it is offered
// a reply character or the programming event is loaded whenever the output register is free
// each record write passes ST_RD then ST_WR, as the buffer read port is registered
// rx is held off from a result-causing byte until its last beat sits in the output register
// a stall on res holds the output register and the reply sequencer
// rst is synchronous; the record buffer needs no clearing pass after it
module serial_record_loader_top (
  input  logic      clk,
  input  logic      rst,
  srl_in_if.sink    rx,
  srl_out_if.source res
);
  import srl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // parser and reply sequencer
  srl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, buffer and output stage
  srl_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

endmodule

// File: rtl/core/srl_chk.sv
// port-level checker for the record loader and its bind
`include "serial_record_loader_top_assert.svh"

module srl_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          rx_valid,
  input logic                          rx_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [1:0]                    res_kind,
  input srl_pkg::byte_t                res_tx_byte,
  input logic [srl_pkg::ADDR_WIDTH-1:0] res_mem_addr,
  input srl_pkg::byte_t                res_mem_data,
  input logic                          res_last
);
  import srl_pkg::*;

  // a stalled beat keeps its payload
  `SRL_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_tx_byte) && $stable(res_mem_addr) && $stable(res_mem_data) && $stable(res_last), "stalled result beat changed")

  // the programming event is always a reply of its own
  `SRL_ASSERT(a_prog_last, res_valid && res_kind == KIND_PROG, res_last, "programming event not marked last")

  // a memory write is always followed by the verdict and carries no character
  `SRL_ASSERT(a_wr_not_last, res_valid && res_kind == KIND_WR, !res_last && res_tx_byte == 8'd0, "memory write marked last or carries a character")

  // no byte is taken while a reply is still incomplete
  `SRL_ASSERT(a_busy_mid_reply, res_valid && !res_last, !rx_ready, "byte taken in the middle of a reply")

endmodule

bind serial_record_loader_top srl_chk u_srl_chk (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx.valid),
  .rx_ready     (rx.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_kind     (res.kind),
  .res_tx_byte  (res.tx_byte),
  .res_mem_addr (res.mem_addr),
  .res_mem_data (res.mem_data),
  .res_last     (res.last)
);
